FILE: src/orfp_pkg.sv
// Shared constants and types for the obstacle record frame parser.
// Holds the slot geometry, the structs passed from the parser to the top level and the output word.
// No dependencies.
package orfp_pkg;

  // Number of obstacle slots held in each angle store.
  localparam int OBSTACLE_SLOTS = 512;
  // Longest distance field folded into the value; anything past four bytes is dropped.
  localparam int MAX_DISTANCE_BYTES = 4;
  localparam int DIST_KEEP = (MAX_DISTANCE_BYTES < 4) ? MAX_DISTANCE_BYTES : 4;
  localparam int SLOT_W = (OBSTACLE_SLOTS > 1) ? $clog2(OBSTACLE_SLOTS) : 1;

  // Write into one of the angle stores.
  typedef struct packed {
    logic              start_we;
    logic              end_we;
    logic [SLOT_W-1:0] addr;
    logic [15:0]       data;
  } orfp_wr_t;

  // Completed record: the slot to read back and the assembled distance.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] addr;
    logic [31:0]       distance;
  } orfp_rec_t;

  // One result word as held in the output and skid registers.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [31:0]       distance;
    logic [15:0]       end_angle;
    logic [15:0]       start_angle;
  } orfp_out_t;

endpackage

FILE: src/orfp_parser.sv
// Frame parser for the obstacle record frame parser: tag decoding, distance
// assembly, slot counting and the idle timeout. Depends on orfp_pkg.
module orfp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              mode,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  output orfp_pkg::orfp_wr_t  wr,
  output orfp_pkg::orfp_rec_t rec
);
  import orfp_pkg::*;

  localparam logic [7:0]  TAG_NONE  = 8'd78;
  localparam logic [7:0]  TAG_START = 8'd83;
  localparam logic [7:0]  TAG_END   = 8'd69;
  localparam logic [7:0]  TAG_DIST  = 8'd68;

  localparam logic [1:0]  KIND_NONE  = 2'd0;
  localparam logic [1:0]  KIND_START = 2'd1;
  localparam logic [1:0]  KIND_END   = 2'd2;
  localparam logic [1:0]  KIND_DIST  = 2'd3;

  localparam logic [1:0]  POS_TAG  = 2'd0;
  localparam logic [1:0]  POS_ONE  = 2'd1;
  localparam logic [1:0]  POS_TWO  = 2'd2;
  localparam logic [1:0]  POS_MORE = 2'd3;

  localparam logic [16:0] IDLE_MAX      = 17'h1FFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(OBSTACLE_SLOTS - 1);

  logic [15:0]       idle_timeout_ms;
  logic [1:0]        frame_kind, frame_kind_next;
  logic [1:0]        byte_position, byte_position_next;
  logic [7:0]        low_byte_hold, low_byte_hold_next;
  logic [7:0]        distance_length, distance_length_next;
  logic [7:0]        distance_bytes_seen, distance_bytes_seen_next;
  logic [31:0]       distance_accum, distance_accum_next;
  logic [SLOT_W-1:0] current_slot, current_slot_next;
  logic [16:0]       idle_ticks, idle_ticks_next;
  logic              timer_running, timer_running_next;

  logic [SLOT_W-1:0] slot_eff;
  logic [7:0]        need;
  logic              finish;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      idle_timeout_ms <= cfg_wdata;
    end
  end

  // Slot after the timeout check, and the byte count a distance needs.
  assign slot_eff = (idle_ticks > {1'b0, idle_timeout_ms}) ? '0 : current_slot;
  assign need     = (distance_length == 8'd0) ? 8'd1 : distance_length;

  // Next state for one word.
  always_comb begin
    frame_kind_next          = frame_kind;
    byte_position_next       = byte_position;
    low_byte_hold_next       = low_byte_hold;
    distance_length_next     = distance_length;
    distance_bytes_seen_next = distance_bytes_seen;
    distance_accum_next      = distance_accum;
    current_slot_next        = current_slot;
    idle_ticks_next          = idle_ticks;
    timer_running_next       = timer_running;
    finish                   = 1'b0;
    wr                       = '0;
    wr.addr                  = slot_eff;
    wr.data                  = {rx_byte, low_byte_hold};

    if (item_valid && mode) begin
      // Millisecond tick: count idle time once the first byte has arrived.
      if (timer_running && idle_ticks != IDLE_MAX) begin
        idle_ticks_next = idle_ticks + 17'd1;
      end
    end else if (item_valid) begin
      current_slot_next  = slot_eff;
      idle_ticks_next    = '0;
      timer_running_next = 1'b1;
      case (byte_position)
        POS_TAG: begin
          if (rx_byte == TAG_NONE) begin
            frame_kind_next = KIND_NONE;
          end else if (rx_byte == TAG_START) begin
            frame_kind_next    = KIND_START;
            byte_position_next = POS_ONE;
          end else if (rx_byte == TAG_END) begin
            frame_kind_next    = KIND_END;
            byte_position_next = POS_ONE;
          end else if (rx_byte == TAG_DIST) begin
            frame_kind_next    = KIND_DIST;
            byte_position_next = POS_ONE;
          end
        end
        POS_ONE: begin
          if (frame_kind == KIND_START || frame_kind == KIND_END) begin
            low_byte_hold_next = rx_byte;
            byte_position_next = POS_TWO;
          end else if (frame_kind == KIND_DIST) begin
            distance_length_next = rx_byte;
            byte_position_next   = POS_TWO;
          end else begin
            byte_position_next = POS_TAG;
          end
        end
        POS_TWO: begin
          if (frame_kind == KIND_START) begin
            wr.start_we        = 1'b1;
            frame_kind_next    = KIND_NONE;
            byte_position_next = POS_TAG;
          end else if (frame_kind == KIND_END) begin
            wr.end_we          = 1'b1;
            frame_kind_next    = KIND_NONE;
            byte_position_next = POS_TAG;
          end else if (frame_kind == KIND_DIST) begin
            // First distance byte restarts the value.
            distance_accum_next      = {24'd0, rx_byte};
            distance_bytes_seen_next = 8'd1;
            if (need <= 8'd1) begin
              finish = 1'b1;
            end else begin
              byte_position_next = POS_MORE;
            end
          end else begin
            byte_position_next = POS_TAG;
          end
        end
        default: begin
          if (frame_kind == KIND_DIST) begin
            // Later distance bytes fill the upper lanes until the value is full.
            if (distance_bytes_seen < 8'(DIST_KEEP)) begin
              case (distance_bytes_seen[1:0])
                2'd0:    distance_accum_next[7:0]   = distance_accum[7:0]   | rx_byte;
                2'd1:    distance_accum_next[15:8]  = distance_accum[15:8]  | rx_byte;
                2'd2:    distance_accum_next[23:16] = distance_accum[23:16] | rx_byte;
                default: distance_accum_next[31:24] = distance_accum[31:24] | rx_byte;
              endcase
            end
            if (distance_bytes_seen != 8'hFF) begin
              distance_bytes_seen_next = distance_bytes_seen + 8'd1;
            end
            if (distance_bytes_seen_next >= need) begin
              finish = 1'b1;
            end
          end else begin
            byte_position_next = POS_TAG;
          end
        end
      endcase

      // A completed distance closes the record and moves to the next slot.
      if (finish) begin
        current_slot_next  = (slot_eff == SLOT_LAST) ? '0 : slot_eff + SLOT_W'(1);
        frame_kind_next    = KIND_NONE;
        byte_position_next = POS_TAG;
      end
    end

    rec.valid    = finish;
    rec.addr     = slot_eff;
    rec.distance = distance_accum_next;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind          <= KIND_NONE;
      byte_position       <= POS_TAG;
      low_byte_hold       <= '0;
      distance_length     <= '0;
      distance_bytes_seen <= '0;
      distance_accum      <= '0;
      current_slot        <= '0;
      idle_ticks          <= '0;
      timer_running       <= 1'b0;
    end else begin
      frame_kind          <= frame_kind_next;
      byte_position       <= byte_position_next;
      low_byte_hold       <= low_byte_hold_next;
      distance_length     <= distance_length_next;
      distance_bytes_seen <= distance_bytes_seen_next;
      distance_accum      <= distance_accum_next;
      current_slot        <= current_slot_next;
      idle_ticks          <= idle_ticks_next;
      timer_running       <= timer_running_next;
    end
  end

endmodule

FILE: src/obstacle_record_frame_parser.sv
// Top level of the obstacle record frame parser: angle stores, read stage and
// output register with skid. Depends on orfp_pkg and orfp_parser.
//
//   channel   direction  tdata                                           tuser
//   s_axis    in         rx_byte[7:0]                                    mode[0]
//   m_axis    out        start_angle, end_angle, distance, slot_index    -
//   cfg       in         idle_timeout_ms[15:0] on cfg_we                 -
//
// One word is accepted per cycle while s_axis_tready is high; a record passes from the
// distance byte that completes it through the angle store read into the read stage
// and then the output register. After reset both angle stores are cleared, one slot a
// cycle, with s_axis_tready low; configuration writes are taken during the pass.
// A stalled m_axis keeps one record in the output register and one in the skid
// register; s_axis_tready drops only once both could be needed.
module obstacle_record_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [15:0] start_angle, [31:16] end_angle,
                                      // [63:32] distance, [72:64] slot_index
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import orfp_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(OBSTACLE_SLOTS - 1);

  logic              accept;
  orfp_wr_t          wr;
  orfp_rec_t         rec;

  logic              clearing;
  logic [SLOT_W-1:0] clr_addr;

  logic              mem_start_we, mem_end_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;

  logic [15:0]       start_mem [OBSTACLE_SLOTS];
  logic [15:0]       end_mem [OBSTACLE_SLOTS];

  logic              rv;
  orfp_out_t         stage_a;
  logic              out_valid;
  orfp_out_t         out_word;
  logic              skid_valid;
  orfp_out_t         skid_word;
  logic              drain;

  assign s_axis_tready = !clearing && !skid_valid && !(rv && out_valid);
  assign accept        = s_axis_tvalid && s_axis_tready;

  orfp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (accept),
    .mode       (s_axis_tuser[0]),
    .rx_byte    (s_axis_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .wr         (wr),
    .rec        (rec)
  );

  // Clearing pass over both angle stores after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + SLOT_W'(1);
      if (clr_addr == SLOT_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // Store write port: zeros during the clearing pass, parser writes otherwise.
  assign mem_start_we = clearing || wr.start_we;
  assign mem_end_we   = clearing || wr.end_we;
  assign mem_waddr    = clearing ? clr_addr : wr.addr;
  assign mem_wdata    = clearing ? 16'd0 : wr.data;

  // Angle stores, read into the stage register when a record completes.
  always_ff @(posedge clk) begin
    if (mem_start_we) begin
      start_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_end_we) begin
      end_mem[mem_waddr] <= mem_wdata;
    end
    if (rec.valid) begin
      stage_a.start_angle <= start_mem[rec.addr];
      stage_a.end_angle   <= end_mem[rec.addr];
      stage_a.distance    <= rec.distance;
      stage_a.slot        <= rec.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      rv <= rec.valid;
    end
  end

  // Output register with one skid entry behind it.
  assign drain = out_valid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || drain) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (rv) begin
        out_word  <= stage_a;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (rv) begin
      skid_word  <= stage_a;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, 9'(out_word.slot), out_word.distance,
                          out_word.end_angle, out_word.start_angle};

  // No word is taken while the stores are being cleared.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("word accepted during clearing pass");

  // The skid entry and the read stage are never occupied together.
  a_skid_rv_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(skid_valid && rv))
    else $error("skid and read stage both hold a record");

  // A record in the skid entry always sits behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid holds a record with the output register empty");

  // A record in the read stage comes from a word accepted the cycle before.
  a_rv_from_accept: assert property (@(posedge clk) disable iff (rst)
    rv |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("record appeared without an accepted word");

endmodule
